FILE: design/di_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// di_pkg: shared constants, types and functions
// Widths, controller command/status structs and the 8-point transform.
// ---------------------------------------------------------------------------
package di_pkg;

  localparam int BlockSide  = 8;
  localparam int BlockItems = BlockSide * BlockSide;
  localparam int IdxW       = $clog2(BlockItems);
  localparam int SideW      = $clog2(BlockSide);
  localparam int CoefW      = 32;

  localparam logic KindFull = 1'b0;
  localparam logic KindDc   = 1'b1;

  typedef logic [CoefW-1:0] word_t;
  typedef word_t [BlockSide-1:0] vec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;      // store an accepted item
    logic              first;     // item is the first of a block
    logic [IdxW-1:0]   load_idx;
    logic              rd_en;     // read coefficient memory
    logic [IdxW-1:0]   rd_idx;
    logic              cap;       // capture read data into line buffer
    logic [SideW-1:0]  cap_pos;
    logic              xf_col;    // 0: row pass, 1: column pass
    logic              wr_en;     // write one transformed word back
    logic [SideW-1:0]  wr_pos;
    logic [IdxW-1:0]   wr_idx;
    logic              out_rd;    // read both memories for output
    logic [IdxW-1:0]   out_idx;
    logic              out_cap;   // register output sample
    logic              out_last;
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic dc_mode;
  } sts_t;

  function automatic word_t asr(input word_t x, input int unsigned n);
    asr = word_t'($signed(x) >>> n);
  endfunction

  function automatic vec_t xform8(input vec_t d);
    word_t a0, a1, a2, a3, a4, a5, a6, a7;
    word_t b0, b1, b2, b3, b4, b5, b6, b7;
    vec_t  r;
    a0 = d[0] + d[4];
    a2 = d[0] - d[4];
    a4 = asr(d[2], 1) - d[6];
    a6 = asr(d[6], 1) + d[2];
    b0 = a0 + a6; b2 = a2 + a4; b4 = a2 - a4; b6 = a0 - a6;
    a1 = d[5] - d[3] - d[7] - asr(d[7], 1);
    a3 = d[1] + d[7] - d[3] - asr(d[3], 1);
    a5 = d[7] - d[1] + d[5] + asr(d[5], 1);
    a7 = d[3] + d[5] + d[1] + asr(d[1], 1);
    b1 = asr(a7, 2) + a1;
    b3 = a3 + asr(a5, 2);
    b5 = asr(a3, 2) - a5;
    b7 = a7 - asr(a1, 2);
    r[0] = b0 + b7; r[7] = b0 - b7;
    r[1] = b2 + b5; r[6] = b2 - b5;
    r[2] = b4 + b3; r[5] = b4 - b3;
    r[3] = b6 + b1; r[4] = b6 - b1;
    xform8 = r;
  endfunction

endpackage

FILE: design/di_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// di_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module di_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/di_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// di_datapath: scaling, transform and reconstruction datapath
// Scales incoming coefficients (unscaled for DC blocks), runs row/column
// passes through one 8-point unit and forms the clipped reconstructed samples.
// ---------------------------------------------------------------------------
module di_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  di_pkg::cmd_t            cmd_i,
  output di_pkg::sts_t            sts_o,
  input  logic                    kind_i,
  input  logic signed [15:0]      coefficient_i,
  input  logic [15:0]             scale_factor_i,
  input  logic [5:0]              quant_param_i,
  input  logic [7:0]              pred_sample_i,
  output logic [7:0]              recon_sample_o,
  output logic                    last_o
);

  logic              mode_q, mode_d;
  logic [5:0]        qp_q, qp_d;
  logic [3:0]        per;
  di_pkg::word_t     c_ext, prod, scaled, wdata, din, rd_coef, res;
  di_pkg::vec_t      line_q, xf_out;
  di_pkg::word_t     dc_q;
  logic              we;
  logic [di_pkg::IdxW-1:0] waddr;
  logic [7:0]        rd_pred, recon_q;
  logic              last_q;
  logic signed [9:0] sum;

  // The first item of a block sets mode and qp for the whole block.
  assign mode_d = cmd_i.first ? kind_i : mode_q;
  assign qp_d   = cmd_i.first ? quant_param_i : qp_q;
  assign per    = 4'((qp_d * 43) >> 8);  // qp/6 for qp < 64

  assign c_ext = di_pkg::word_t'(coefficient_i);
  assign prod  = c_ext * {16'd0, scale_factor_i};

  always_comb begin
    if (per >= 4'd6) scaled = prod << (per - 4'd6);
    else scaled = di_pkg::asr(prod + (di_pkg::word_t'(1) << (4'd5 - per)),
                              32'(4'd6 - per));
  end

  assign din = mode_d ? c_ext : scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      qp_q   <= '0;
      last_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      qp_q   <= qp_d;
      if (cmd_i.out_cap) last_q <= cmd_i.out_last;
    end
  end

  assign xf_out = di_pkg::xform8(line_q);
  assign we     = cmd_i.load | cmd_i.wr_en;
  assign waddr  = cmd_i.load ? cmd_i.load_idx : cmd_i.wr_idx;
  assign wdata  = cmd_i.load ? din : xf_out[cmd_i.wr_pos];

  di_ram #(.Width(di_pkg::CoefW), .Depth(di_pkg::BlockItems)) u_coef (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(cmd_i.rd_en | cmd_i.out_rd),
    .raddr_i(cmd_i.out_rd ? cmd_i.out_idx : cmd_i.rd_idx),
    .rdata_o(rd_coef)
  );

  di_ram #(.Width(8), .Depth(di_pkg::BlockItems)) u_pred (
    .clk_i, .we_i(cmd_i.load), .waddr_i(cmd_i.load_idx), .wdata_i(pred_sample_i),
    .re_i(cmd_i.out_rd), .raddr_i(cmd_i.out_idx), .rdata_o(rd_pred)
  );

  // The line buffer holds one row or column; a DC copy keeps the first value.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) line_q[cmd_i.cap_pos] <= rd_coef;
    if (cmd_i.load && cmd_i.first) dc_q <= c_ext;
    if (cmd_i.out_cap) recon_q <= sum > 10'sd255 ? 8'd255 :
                                  sum < 10'sd0 ? 8'd0 : sum[7:0];
  end

  assign res = di_pkg::asr((mode_q ? dc_q : rd_coef) + 32'd32, 6);

  // Saturate the residual to -256..256, held in 10 bits, before the add.
  always_comb begin
    logic signed [31:0] r;
    r = $signed(res);
    if (r > 32'sd256) sum = 10'sd256;
    else if (r < -32'sd256) sum = -10'sd256;
    else sum = r[9:0];
    sum = sum + $signed({2'b00, rd_pred});
  end

  assign recon_sample_o = recon_q;
  assign last_o         = last_q;
  assign sts_o.dc_mode  = mode_q;

endmodule

FILE: design/di_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// di_ctrl: sequencer for load, transform passes and output
// ---------------------------------------------------------------------------
module di_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output di_pkg::cmd_t cmd_o,
  input  di_pkg::sts_t sts_i
);

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StWrite = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0] state_q, state_d;
  logic [di_pkg::IdxW-1:0] cnt_q, cnt_d;   // item / output index
  logic [di_pkg::SideW-1:0] line_q, line_d;
  logic [di_pkg::SideW:0] pos_q, pos_d;    // read/write step within a line
  logic pass_q, pass_d;
  logic rd_v_q;
  logic ov_q, ov_d;
  logic [di_pkg::SideW-1:0] rpos;
  logic acc;

  assign in_ready_o  = state_q == StLoad;
  assign acc         = in_valid_i & in_ready_o;
  assign out_valid_o = ov_q;
  assign rpos        = pos_q[di_pkg::SideW-1:0];

  function automatic logic [di_pkg::IdxW-1:0] addr(input logic col,
      input logic [di_pkg::SideW-1:0] ln, input logic [di_pkg::SideW-1:0] p);
    addr = col ? {p, ln} : {ln, p};
  endfunction

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; line_d = line_q;
    pos_d = pos_q; pass_d = pass_q; ov_d = ov_q;
    cmd_o = '0;
    cmd_o.load     = acc;
    cmd_o.first    = acc && cnt_q == '0;
    cmd_o.load_idx = cnt_q;
    cmd_o.xf_col   = pass_q;
    cmd_o.cap      = rd_v_q;
    cmd_o.cap_pos  = rpos - 1'b1;
    case (state_q)
      StLoad: if (acc) begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          line_d = '0; pos_d = '0; pass_d = 1'b0;
          state_d = StRead;
        end
      end
      StRead: begin
        if (sts_i.dc_mode) begin
          state_d = StOut;
        end else if (pos_q[di_pkg::SideW]) begin
          pos_d = '0; state_d = StWrite;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_idx = addr(pass_q, line_q, rpos);
          pos_d = pos_q + 1'b1;
        end
        if (pos_q == '0) cmd_o.cap = 1'b0;
      end
      StWrite: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_pos = rpos;
        cmd_o.wr_idx = addr(pass_q, line_q, rpos);
        pos_d = pos_q + 1'b1;
        if (rpos == '1) begin
          pos_d = '0; line_d = line_q + 1'b1; state_d = StRead;
          if (line_q == '1) begin
            if (pass_q) state_d = StOut;
            pass_d = ~pass_q;
          end
        end
      end
      StOut: begin
        cmd_o.out_rd = 1'b1; cmd_o.out_idx = cnt_q; state_d = StEmit;
      end
      StEmit: begin
        cmd_o.out_cap  = !ov_q;
        cmd_o.out_last = cnt_q == '1;
        if (!ov_q) ov_d = 1'b1;
        else if (out_ready_i) begin
          ov_d = 1'b0; cnt_d = cnt_q + 1'b1;
          state_d = cnt_q == '1 ? StLoad : StOut;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad; cnt_q <= '0; line_q <= '0; pos_q <= '0;
      pass_q <= 1'b0; rd_v_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; line_q <= line_d; pos_q <= pos_d;
      pass_q <= pass_d; rd_v_q <= cmd_o.rd_en; ov_q <= ov_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("accept while output pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("output dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.wr_en)) else $error("write port conflict");

endmodule

FILE: design/dequant_idct8x8_add.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dequant_idct8x8_add: 8x8 dequantization, inverse transform and add
// Top level joining the sequencer and the datapath.
// ---------------------------------------------------------------------------
// Usage: an 8x8 block arrives as 64 input transactions in raster order on
// the in_valid_i/in_ready_o channel, one per cycle at most. Kind and
// quant_param are taken from the first transaction of each block. After the
// 64th transaction the block runs 16 passes (8 rows, 8 columns), each a read
// phase that fills a line buffer and a write phase that stores the output of
// the one 8-point transform unit back to coefficient memory; DC blocks skip
// this. It then delivers 64 output transactions on out_valid_o/out_ready_i,
// each a memory read, a capture and a handshake, with last_o on the 64th.
// The phases run one after another, so a new block is taken only after the
// last output of the previous one is accepted. No input is taken while
// output is pending. A stalled receiver holds the current sample steady.
// Reset returns the sequencer to waiting for a first item; the memories
// are not cleared, as every entry is written before use.
// ---------------------------------------------------------------------------
module dequant_idct8x8_add (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic signed [15:0] coefficient_i,
  input  logic [15:0]        scale_factor_i,
  input  logic [5:0]         quant_param_i,
  input  logic [7:0]         pred_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         recon_sample_o,
  output logic               last_o
);

  di_pkg::cmd_t cmd;
  di_pkg::sts_t sts;

  di_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  di_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .kind_i, .coefficient_i,
    .scale_factor_i, .quant_param_i, .pred_sample_i, .recon_sample_o, .last_o
  );

endmodule
